### hw/rtl/fld_pkg.sv
// fld_pkg: shared types and constants for the flag/length frame deframer
// used by fld_parser, flag_length_frame_deframer_core and fld_checker
package fld_pkg;

    localparam int LENGTH_BYTES = 8;
    localparam int LEN_CNT_W    = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

    localparam int PADDR_W      = 4;
    localparam int TDATA_IN_W   = 8;
    localparam int TDATA_OUT_W  = 8;
    localparam int TUSER_OUT_W  = 2;

    localparam logic [1:0] REG_START_FLAG  = 2'd0;
    localparam logic [1:0] REG_END_FLAG    = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [7:0]  START_FLAG_RESET  = 8'd2;
    localparam logic [7:0]  END_FLAG_RESET    = 8'd3;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_BAD_END  = 2'd1,
        KIND_TOO_LONG = 2'd2,
        KIND_EMPTY    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  start_flag;
        logic [7:0]  end_flag;
        logic [31:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } result_t;

endpackage

### hw/rtl/fld_parser.sv
// fld_parser: frame phase tracking and per-byte result logic
// depends on fld_pkg
module fld_parser
    import fld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2,
        PH_END  = 2'd3
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            len_low_reg, len_low_next;
    logic                   len_high_reg, len_high_next;
    logic [LEN_CNT_W-1:0]   len_cnt_reg, len_cnt_next;
    logic [31:0]            remaining_reg, remaining_next;
    logic                   empty_reg, empty_next;

    logic [2:0]             cnt_idx;
    logic [31:0]            len_low_acc;
    logic                   len_high_acc;
    logic                   len_done;

    assign cnt_idx  = 3'(len_cnt_reg);
    assign len_done = (len_cnt_reg == LEN_CNT_W'(LENGTH_BYTES - 1));

    always_comb
    begin
        len_low_acc  = len_low_reg;
        len_high_acc = len_high_reg;
        case (cnt_idx)
            3'd0: len_low_acc[7:0]   = data_byte;
            3'd1: len_low_acc[15:8]  = data_byte;
            3'd2: len_low_acc[23:16] = data_byte;
            3'd3: len_low_acc[31:24] = data_byte;
            default: len_high_acc    = len_high_reg | (data_byte != 8'd0);
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        len_low_next   = len_low_reg;
        len_high_next  = len_high_reg;
        len_cnt_next   = len_cnt_reg;
        remaining_next = remaining_reg;
        empty_next     = empty_reg;
        res            = '0;
        res.kind       = KIND_PAYLOAD;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (data_byte == cfg.start_flag)
                begin
                    phase_next    = PH_LEN;
                    len_low_next  = '0;
                    len_high_next = 1'b0;
                    len_cnt_next  = '0;
                end
            end
            PH_LEN:
            begin
                len_low_next  = len_low_acc;
                len_high_next = len_high_acc;
                len_cnt_next  = len_cnt_reg + LEN_CNT_W'(1);
                if (len_done)
                begin
                    if (len_high_acc || (len_low_acc > cfg.max_payload))
                    begin
                        phase_next = PH_HUNT;
                        res.valid  = 1'b1;
                        res.kind   = KIND_TOO_LONG;
                    end
                    else
                    begin
                        remaining_next = len_low_acc;
                        empty_next     = (len_low_acc == 32'd0);
                        phase_next     = (len_low_acc == 32'd0) ? PH_END : PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                res.valid         = 1'b1;
                res.kind          = KIND_PAYLOAD;
                res.payload_byte  = data_byte;
                res.last_of_frame = (remaining_reg <= 32'd1);
                if (remaining_reg != 32'd0)
                    remaining_next = remaining_reg - 32'd1;
                if (remaining_reg <= 32'd1)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                phase_next = PH_HUNT;
                if (data_byte != cfg.end_flag)
                begin
                    res.valid = 1'b1;
                    res.kind  = KIND_BAD_END;
                end
                else if (empty_reg)
                begin
                    empty_next = 1'b0;
                    res.valid  = 1'b1;
                    res.kind   = KIND_EMPTY;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
        if (!advance)
            res.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            len_low_reg   <= '0;
            len_high_reg  <= 1'b0;
            len_cnt_reg   <= '0;
            remaining_reg <= '0;
            empty_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            len_low_reg   <= len_low_next;
            len_high_reg  <= len_high_next;
            len_cnt_reg   <= len_cnt_next;
            remaining_reg <= remaining_next;
            empty_reg     <= empty_next;
        end
    end

endmodule

### hw/rtl/flag_length_frame_deframer_core.sv
// flag_length_frame_deframer_core: top level with stream ports and register port
// depends on fld_pkg and fld_parser
//
// Usage:
//   Bytes enter on the s_ group, one per transaction. Bytes are dropped until
//   the start flag, then LENGTH_BYTES length bytes (least significant first)
//   are gathered, payload bytes go out on the m_ group with m_tlast on the
//   final one, and the following byte must equal the end flag.
//   Results out: kind in m_tuser[1:0], payload byte in m_tdata[7:0].
//   A bad end flag, an oversized length and an empty frame each give a single
//   result transaction of their own kind.
//   Path: an accepted byte waits in the input register, the parser acts on it
//   combinationally, and its result is taken into the output register.
//   Throughput: one byte per cycle while m_tready is high, set by the input
//   register feeding the parser and a single output register.
//   Receiver stall: the output register holds its transaction; the input
//   register keeps its byte (taking one more if it was empty), then s_tready
//   stays low until m_tready returns.
//   Reset: all flags and counters clear, phase returns to hunting, registers
//   take start_flag 2, end_flag 3, max_payload 65536. Registers are written
//   through the APB port; the user must keep the stream idle (not enforced).
module flag_length_frame_deframer_core
    import fld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] data_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] payload_byte
    output logic [TUSER_OUT_W-1:0] m_tuser,   // [1:0] kind
    output logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       advance;
    logic       cfg_write;
    logic [1:0] reg_idx;
    result_t    res;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_flag  <= START_FLAG_RESET;
            cfg_reg.end_flag    <= END_FLAG_RESET;
            cfg_reg.max_payload <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_START_FLAG:  cfg_reg.start_flag  <= pwdata[7:0];
                REG_END_FLAG:    cfg_reg.end_flag    <= pwdata[7:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START_FLAG:  prdata = {24'd0, cfg_reg.start_flag};
            REG_END_FLAG:    prdata = {24'd0, cfg_reg.end_flag};
            REG_MAX_PAYLOAD: prdata = cfg_reg.max_payload;
            default:         prdata = 32'd0;
        endcase
    end

    // input stage
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    fld_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res.valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.payload_byte;
            out_last_reg <= res.last_of_frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/fld_checker.sv
// fld_checker: port-level assertions for the deframer top level, with bind
// depends on fld_pkg and flag_length_frame_deframer_core
module fld_checker
    import fld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic [TUSER_OUT_W-1:0] m_tuser,
    input  logic                   m_tlast
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // only payload transactions may close a frame
    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == KIND_PAYLOAD)
        else $error("tlast on a non-payload transaction");

    // event transactions carry a zero byte
    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_PAYLOAD |-> m_tdata == 8'd0)
        else $error("event transaction with nonzero byte");

    // nothing pending right after reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind flag_length_frame_deframer_core fld_checker u_fld_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/frame_result_checker.sv
`timescale 1ns / 1ps
// frame_result_checker: watches byte, result and register transactions of
// flag_length_frame_deframer_core, predicts every result and compares them
// depends on fld_pkg for widths, register indexes, reset values and kind_t
module frame_result_checker
    import fld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] payload_byte
    input  logic [TUSER_OUT_W-1:0] m_tuser,   // [1:0] kind
    input  logic                   m_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    output int                     fail_count,
    output int                     pending,
    output int                     results_seen
);

    typedef enum logic [1:0] {
        HUNT,
        LENGTH,
        PAYLOAD,
        END_CHECK
    } parse_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } frame_out_t;

    frame_out_t   expected_q[$];

    logic [7:0]   start_flag;
    logic [7:0]   end_flag;
    logic [31:0]  max_payload;

    parse_phase_t phase;
    logic [63:0]  len_acc;
    logic [3:0]   len_cnt;
    logic [31:0]  remaining;
    logic         was_empty;

    task automatic push_result(input kind_t k, input logic [7:0] d, input logic l);
        frame_out_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        expected_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_flag   = START_FLAG_RESET;
            end_flag     = END_FLAG_RESET;
            max_payload  = MAX_PAYLOAD_RESET;
            phase        = HUNT;
            len_acc      = '0;
            len_cnt      = '0;
            remaining    = '0;
            was_empty    = 1'b0;
            expected_q.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin : compare_result
                frame_out_t got;
                frame_out_t want;
                got.kind = kind_t'(m_tuser[1:0]);
                got.data = m_tdata[7:0];
                got.last = m_tlast;
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: expected no result, got kind %0d byte %02h last %0b",
                             $time, got.kind, got.data, got.last);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: expected kind %0d byte %02h last %0b,",
                                 $time, want.kind, want.data, want.last,
                                 " got kind %0d byte %02h last %0b",
                                 got.kind, got.data, got.last);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin : predict_from_byte
                logic [7:0] b;
                logic       last;
                b = s_tdata[7:0];
                case (phase)
                    HUNT:
                    begin
                        if (b == start_flag)
                        begin
                            phase   = LENGTH;
                            len_acc = '0;
                            len_cnt = '0;
                        end
                    end
                    LENGTH:
                    begin
                        // length arrives least significant byte first
                        len_acc = len_acc | ({56'd0, b} << (8 * len_cnt[2:0]));
                        len_cnt = len_cnt + 4'd1;
                        if (len_cnt >= LENGTH_BYTES)
                        begin
                            if (len_acc > {32'd0, max_payload})
                            begin
                                phase = HUNT;
                                push_result(KIND_TOO_LONG, 8'h00, 1'b0);
                            end
                            else
                            begin
                                remaining = len_acc[31:0];
                                was_empty = (remaining == 32'd0);
                                if (remaining == 32'd0)
                                    phase = END_CHECK;
                                else
                                    phase = PAYLOAD;
                            end
                        end
                    end
                    PAYLOAD:
                    begin
                        last = (remaining <= 32'd1);
                        if (remaining != 32'd0)
                            remaining = remaining - 32'd1;
                        if (remaining == 32'd0)
                            phase = END_CHECK;
                        push_result(KIND_PAYLOAD, b, last);
                    end
                    default:
                    begin
                        // a bad end byte is never taken as a new start flag
                        phase = HUNT;
                        if (b != end_flag)
                            push_result(KIND_BAD_END, 8'h00, 1'b0);
                        else if (was_empty)
                        begin
                            was_empty = 1'b0;
                            push_result(KIND_EMPTY, 8'h00, 1'b0);
                        end
                    end
                endcase
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_START_FLAG:  start_flag  = pwdata[7:0];
                    REG_END_FLAG:    end_flag    = pwdata[7:0];
                    REG_MAX_PAYLOAD: max_payload = pwdata;
                    default:         ;
                endcase
            end

            pending = expected_q.size();
        end
    end

endmodule

### tb/flag_length_frame_deframer_core_test.sv
`timescale 1ns / 1ps
// flag_length_frame_deframer_core_test: drives framed byte streams and register
// settings into flag_length_frame_deframer_core; frame_result_checker judges results
// depends on fld_pkg, frame_result_checker and the deframer RTL
module flag_length_frame_deframer_core_test
    import fld_pkg::*;
;

    localparam logic [1:0] REG_SPARE   = 2'd3;
    localparam int         HOLD_CYCLES = 150;
    localparam int         PHASE_ITEMS = 180;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int                     fail_count;
    int                     pending;
    int                     results_seen;

    logic                   idle_on  = 1'b1;
    logic                   hold_req = 1'b0;
    logic [7:0]             cur_start = START_FLAG_RESET;
    logic [7:0]             cur_end   = END_FLAG_RESET;
    logic [31:0]            cur_max   = MAX_PAYLOAD_RESET;
    logic [7:0]             frame_bytes[$];
    int                     bytes_sent     = 0;
    int                     settings_used  = 1;

    flag_length_frame_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    frame_result_checker frame_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input logic [7:0] sf, input logic [7:0] ef, input logic [31:0] mx);
        apb_write(REG_START_FLAG, {24'd0, sf});
        apb_write(REG_END_FLAG, {24'd0, ef});
        apb_write(REG_MAX_PAYLOAD, mx);
        cur_start = sf;
        cur_end   = ef;
        cur_max   = mx;
        settings_used++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (idle_on)
        begin
            while ($urandom_range(0, 99) < 11)
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_queued();
        while (frame_bytes.size() > 0)
            send_byte(frame_bytes.pop_front());
    endtask

    // stream stopped, every result back, pipeline drained
    task automatic wait_quiet();
        s_tvalid = 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic push_length(input logic [63:0] len);
        for (int i = 0; i < LENGTH_BYTES; i++)
            frame_bytes.push_back(len[8*i +: 8]);
    endtask

    function automatic logic [63:0] good_length();
        int unsigned cap;
        int unsigned r;
        cap = (cur_max < 16) ? cur_max : 16;
        r   = $urandom_range(0, 19);
        if (cur_max == 0 || r == 0)
            return 64'd0;
        if (r == 1)
            return 64'($urandom_range(1, (cur_max < 200) ? cur_max : 200));
        if (r == 2 && cur_max <= 300)
            return {32'd0, cur_max};
        return 64'($urandom_range(1, cap));
    endfunction

    function automatic logic [63:0] long_length();
        logic [31:0] upper;
        logic [31:0] lower;
        int unsigned r;
        upper = $urandom;
        lower = $urandom;
        r     = $urandom_range(0, 2);
        if (cur_max != 32'hFFFF_FFFF && r == 0)
            return {32'd0, cur_max} + 64'd1;
        if (cur_max != 32'hFFFF_FFFF && r == 1)
            return {32'd0, 32'($urandom_range(cur_max + 1, 32'hFFFF_FFFF))};
        if (upper == 32'd0)
            upper = 32'd1;
        return {upper, lower};
    endfunction

    task automatic queue_frame();
        int unsigned r;
        logic [63:0] len;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r >= 87 && r < 95)
        begin
            // line noise, never a start flag
            repeat ($urandom_range(1, 4))
            begin
                b = 8'($urandom);
                while (b == cur_start)
                    b = 8'($urandom);
                frame_bytes.push_back(b);
            end
        end
        else if (r >= 67 && r < 77)
        begin
            frame_bytes.push_back(cur_start);
            push_length(long_length());
        end
        else
        begin
            frame_bytes.push_back(cur_start);
            len = (r >= 77 && r < 87) ? 64'd0 : good_length();
            push_length(len);
            repeat (len)
                frame_bytes.push_back(8'($urandom));
            if (r < 55 || (r >= 77 && r < 87))
                b = cur_end;
            else if (r >= 95 && cur_start != cur_end)
                b = cur_start;
            else
            begin
                b = 8'($urandom);
                while (b == cur_end)
                    b = 8'($urandom);
            end
            frame_bytes.push_back(b);
        end
    endtask

    initial
    begin : receiver
        int   held;
        logic hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready = !(idle_on && $urandom_range(0, 99) < 11);
        end
    end

    initial
    begin : stimulus
        int phase_start;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // oversized length, max_payload lowered after three of the eight length bytes
        send_byte(cur_start);
        send_byte(8'd5);
        send_byte(8'd0);
        send_byte(8'd0);
        wait_quiet();
        apb_write(REG_MAX_PAYLOAD, 32'd4);
        cur_max = 32'd4;
        repeat (5) send_byte(8'd0);
        wait_quiet();
        apb_write(REG_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
        cur_max = MAX_PAYLOAD_RESET;

        // empty frame, then a two byte frame with extreme payload values
        send_byte(cur_start);
        repeat (8) send_byte(8'd0);
        send_byte(cur_end);
        send_byte(cur_start);
        send_byte(8'd2);
        repeat (7) send_byte(8'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_end);

        for (int p = 0; p < 6; p++)
        begin
            wait_quiet();
            case (p)
                0: configure(8'h00, 8'hFF, 32'hFFFF_FFFF);
                1: configure(8'hFF, 8'h00, 32'd0);
                2: configure(8'h7E, 8'h7E, 32'd5);
                3: configure(8'($urandom), 8'($urandom), 32'd300);
                4:
                begin
                    apb_write(REG_SPARE, $urandom);
                    configure(START_FLAG_RESET, END_FLAG_RESET, MAX_PAYLOAD_RESET);
                end
                default: configure(8'($urandom), 8'($urandom), $urandom_range(0, 40));
            endcase
            idle_on     = (p != 2);
            phase_start = bytes_sent;
            if (p == 0)
            begin
                // receiver stalls while a long frame keeps arriving
                hold_req = 1'b1;
                frame_bytes.push_back(cur_start);
                push_length(64'd48);
                repeat (48)
                    frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(cur_end);
                send_queued();
            end
            while (bytes_sent - phase_start < PHASE_ITEMS)
            begin
                queue_frame();
                send_queued();
            end
        end

        wait_quiet();
        $display("sent %0d stream bytes under %0d register settings, checked %0d results",
                 bytes_sent, settings_used, results_seen);
        if (fail_count == 0)
            $display("flag_length_frame_deframer_core_test OK");
        else
            $display("flag_length_frame_deframer_core_test NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("flag_length_frame_deframer_core_test NOT OK");
        $finish;
    end

endmodule
